/* hw/rtl/swal_pkg.sv */
// Shared constants and types for the spool weight average to length block.
`timescale 1ns / 1ps

package swal_pkg;

  localparam int SAMPLE_W   = 22;
  localparam int NET_W      = 23;
  localparam int LEN_W      = 20;
  localparam int TARE_W     = 13;
  localparam int GAIN_W     = 18;
  localparam int STEP_W     = 16;
  localparam int TARE_CG_W  = 20;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int GAIN_FRAC  = 16;
  // Positive net weight never exceeds this many bits.
  localparam int NET_POS_W  = 21;

  localparam int NET_MIN     = -2500000;
  localparam int NET_MAX     = 2000000;
  localparam int LEN_MAX     = 700000;
  localparam int SHOWN_RESET = -100;
  localparam int CG_PER_G    = 100;

  localparam int TARE_RESET  = 250;
  localparam int GAIN_RESET  = 21974;
  localparam int WSTEP_RESET = 10;
  localparam int LSTEP_RESET = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARE  = 2'd0,
    CFG_GAIN  = 2'd1,
    CFG_WSTEP = 2'd2,
    CFG_LSTEP = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [TARE_CG_W-1:0] tare_cg;
    logic [GAIN_W-1:0]    gain;
    logic [STEP_W-1:0]    weight_step;
    logic [STEP_W-1:0]    length_step;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic signed [NET_W-1:0] net;
  } net_stage_t;

endpackage

/* hw/rtl/swal_in_if.sv */
// Input channel carrying one scale sample per transfer.
`timescale 1ns / 1ps

interface swal_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swal_pkg::SAMPLE_W-1:0] sample_cg;

  modport source (output valid, output sample_cg, input ready);
  modport sink (input valid, input sample_cg, output ready);
endinterface

/* hw/rtl/swal_out_if.sv */
// Output channel carrying one weight and length result per transfer.
`timescale 1ns / 1ps

interface swal_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [swal_pkg::NET_W-1:0] net_cg;
  logic [swal_pkg::LEN_W-1:0]        length_cm;
  logic                              is_empty;
  logic                              weight_changed;
  logic                              length_changed;

  modport source (output valid, output net_cg, output length_cm, output is_empty,
                  output weight_changed, output length_changed, input ready);
  modport sink (input valid, input net_cg, input length_cm, input is_empty,
                input weight_changed, input length_changed, output ready);
endinterface

/* hw/rtl/swal_ring.sv */
// Sample ring with a running total, updated on every input transfer.
`timescale 1ns / 1ps

module swal_ring #(
  parameter int AVG_DEPTH = 5,
  parameter int TOTAL_W   = 25
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic signed [swal_pkg::SAMPLE_W-1:0] in_sample_i,
  output logic                               in_ready_o,
  output logic                               tot_valid_o,
  output logic signed [TOTAL_W-1:0]          tot_o,
  input  logic                               tot_ready_i
);
  import swal_pkg::*;

  localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

  logic signed [SAMPLE_W-1:0] ring_q [AVG_DEPTH];
  logic [SLOT_W-1:0]          slot_q, slot_d;
  logic signed [TOTAL_W-1:0]  total_q, total_d;
  logic                       valid_q;
  logic                       accept;

  assign in_ready_o = !valid_q || tot_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // The slot being overwritten leaves the total as the new sample enters it.
  assign total_d = total_q + TOTAL_W'(in_sample_i) - TOTAL_W'(ring_q[slot_q]);
  assign slot_d  = (slot_q == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      slot_q  <= '0;
      total_q <= '0;
      valid_q <= 1'b0;
    end else if (accept) begin
      ring_q[slot_q] <= in_sample_i;
      slot_q         <= slot_d;
      total_q        <= total_d;
      valid_q        <= 1'b1;
    end else if (tot_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign tot_valid_o = valid_q;
  assign tot_o       = total_q;

endmodule

/* hw/rtl/swal_net.sv */
// Average by reciprocal multiply, tare subtraction and clamping to the net range.
`timescale 1ns / 1ps

module swal_net #(
  parameter int AVG_DEPTH = 5,
  parameter int TOTAL_W   = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tot_valid_i,
  input  logic signed [TOTAL_W-1:0]     tot_i,
  output logic                          tot_ready_o,
  input  logic [swal_pkg::TARE_CG_W-1:0] tare_cg_i,
  output swal_pkg::net_stage_t          net_o,
  input  logic                          net_ready_i
);
  import swal_pkg::*;

  // Exact truncating division for magnitudes below 2**TOTAL_W.
  localparam int          SHIFT   = TOTAL_W + $clog2(AVG_DEPTH);
  localparam longint      RECIP   = ((64'sd1 <<< SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam int          RECIP_W = $clog2(RECIP + 1);
  localparam int          PROD_W  = TOTAL_W + RECIP_W;
  localparam int          DIFF_W  = TOTAL_W + 1;
  localparam logic [RECIP_W-1:0]       RECIP_C = RECIP_W'(RECIP);
  localparam logic signed [DIFF_W-1:0] NET_MIN_D = DIFF_W'(NET_MIN);
  localparam logic signed [DIFF_W-1:0] NET_MAX_D = DIFF_W'(NET_MAX);

  logic                    va_q, vb_q;
  logic                    ready_a, ready_b;
  logic                    neg_q;
  logic [PROD_W-1:0]       prod_q;
  logic [TOTAL_W-1:0]      mag;
  logic [PROD_W-1:0]       quot_full;
  logic signed [TOTAL_W-1:0] avg;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [NET_W-1:0]   net_d, net_q;

  assign ready_b     = !vb_q || net_ready_i;
  assign ready_a     = !va_q || ready_b;
  assign tot_ready_o = ready_a;

  assign mag = tot_i[TOTAL_W-1] ? TOTAL_W'(-tot_i) : TOTAL_W'(tot_i);

  assign quot_full = prod_q >> SHIFT;
  assign avg       = neg_q ? -$signed(quot_full[TOTAL_W-1:0])
                           : $signed(quot_full[TOTAL_W-1:0]);
  assign diff      = DIFF_W'(avg) - $signed({{(DIFF_W - TARE_CG_W){1'b0}}, tare_cg_i});

  always_comb begin
    if (diff < NET_MIN_D) begin
      net_d = NET_W'(NET_MIN);
    end else if (diff > NET_MAX_D) begin
      net_d = NET_W'(NET_MAX);
    end else begin
      net_d = diff[NET_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_a) begin
        va_q <= tot_valid_i;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && tot_valid_i) begin
      neg_q  <= tot_i[TOTAL_W-1];
      prod_q <= PROD_W'(mag) * PROD_W'(RECIP_C);
    end
    if (ready_b && va_q) begin
      net_q <= net_d;
    end
  end

  assign net_o.valid = vb_q;
  assign net_o.net   = net_q;

endmodule

/* hw/rtl/swal_len.sv */
// Length multiply, clamping and change detection against the shown values.
`timescale 1ns / 1ps

module swal_len (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swal_pkg::net_stage_t net_i,
  output logic                 net_ready_o,
  input  swal_pkg::cfg_t       cfg_i,
  swal_out_if.source           result_o
);
  import swal_pkg::*;

  localparam int PROD_W = NET_POS_W + GAIN_W;
  localparam int SCL_W  = PROD_W - GAIN_FRAC;
  localparam int WD_W   = NET_W + 1;
  localparam int LD_W   = LEN_W + 2;

  logic                    vc_q, vo_q;
  logic                    ready_c, ready_o;
  logic signed [NET_W-1:0] net_c_q;
  logic                    pos_c_q;
  logic [PROD_W-1:0]       prod_q;
  logic                    pos;

  logic [SCL_W-1:0]          scaled;
  logic [LEN_W-1:0]          len;
  logic signed [WD_W-1:0]    wdiff;
  logic [WD_W-1:0]           wabs;
  logic signed [LD_W-1:0]    ldiff;
  logic [LD_W-1:0]           labs;
  logic                      wchg, lchg;

  logic signed [NET_W-1:0]   shown_w_q;
  logic signed [LEN_W:0]     shown_l_q;

  logic signed [NET_W-1:0]   net_out_q;
  logic [LEN_W-1:0]          len_out_q;
  logic                      empty_q, wchg_q, lchg_q;

  assign ready_o     = !vo_q || result_o.ready;
  assign ready_c     = !vc_q || ready_o;
  assign net_ready_o = ready_c;

  assign pos = !net_i.net[NET_W-1] && (net_i.net != '0);

  assign scaled = prod_q[PROD_W-1:GAIN_FRAC];
  assign len    = (scaled > SCL_W'(LEN_MAX)) ? LEN_W'(LEN_MAX) : scaled[LEN_W-1:0];

  assign wdiff = WD_W'(net_c_q) - WD_W'(shown_w_q);
  assign wabs  = wdiff[WD_W-1] ? WD_W'(-wdiff) : WD_W'(wdiff);
  assign ldiff = $signed({2'b00, len}) - LD_W'(shown_l_q);
  assign labs  = ldiff[LD_W-1] ? LD_W'(-ldiff) : LD_W'(ldiff);

  assign wchg = pos_c_q && (wabs > WD_W'(cfg_i.weight_step));
  assign lchg = pos_c_q && (labs > LD_W'(cfg_i.length_step));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q      <= 1'b0;
      vo_q      <= 1'b0;
      shown_w_q <= NET_W'(SHOWN_RESET);
      shown_l_q <= (LEN_W + 1)'(SHOWN_RESET);
    end else begin
      if (ready_c) begin
        vc_q <= net_i.valid;
      end
      if (ready_o) begin
        vo_q <= vc_q;
      end
      // Shown values move only when an item enters the result register.
      if (ready_o && vc_q) begin
        if (!pos_c_q) begin
          shown_w_q <= NET_W'(SHOWN_RESET);
          shown_l_q <= (LEN_W + 1)'(SHOWN_RESET);
        end else begin
          if (wchg) begin
            shown_w_q <= net_c_q;
          end
          if (lchg) begin
            shown_l_q <= $signed({1'b0, len});
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_c && net_i.valid) begin
      net_c_q <= net_i.net;
      pos_c_q <= pos;
      prod_q  <= pos ? PROD_W'(net_i.net[NET_POS_W-1:0]) * PROD_W'(cfg_i.gain) : '0;
    end
    if (ready_o && vc_q) begin
      net_out_q <= net_c_q;
      len_out_q <= pos_c_q ? len : '0;
      empty_q   <= !pos_c_q;
      wchg_q    <= wchg;
      lchg_q    <= lchg;
    end
  end

  assign result_o.valid          = vo_q;
  assign result_o.net_cg         = net_out_q;
  assign result_o.length_cm      = len_out_q;
  assign result_o.is_empty       = empty_q;
  assign result_o.weight_changed = wchg_q;
  assign result_o.length_changed = lchg_q;

endmodule

/* hw/rtl/spool_weight_average_to_length_unit.sv */
// Top level: configuration registers and the averaging and length pipeline.
//
//   Channel    Direction  Contents
//   sample_i   in         sample_cg, one scale reading per transfer
//   result_o   out        net_cg, length_cm, is_empty, weight_changed, length_changed
//   cfg_*_i    in         register write: cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// One sample is taken per cycle while sample_i.ready is high; each result then passes through the stages in order.
// The stages are: ring and running total, reciprocal multiply, net and clamp,
// length multiply, and the result register holding the shown-value compare.
// Reset clears the ring and the total, sets the shown values to SHOWN_RESET and loads register defaults.
// A stall on result_o backs up stage by stage; sample_i.ready drops only when full.
`timescale 1ns / 1ps

module spool_weight_average_to_length_unit #(
  parameter int AVG_DEPTH = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [swal_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [swal_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  swal_in_if.sink                           sample_i,
  swal_out_if.source                        result_o
);
  import swal_pkg::*;

  localparam int TOTAL_W = SAMPLE_W + $clog2(AVG_DEPTH);

  cfg_t                      cfg_q;
  logic                      tot_valid, tot_ready;
  logic signed [TOTAL_W-1:0] tot;
  net_stage_t                net_stage;
  logic                      net_ready;

  // The tare is kept in centigrams so the pipeline only subtracts it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tare_cg     <= TARE_CG_W'(TARE_RESET * CG_PER_G);
      cfg_q.gain        <= GAIN_W'(GAIN_RESET);
      cfg_q.weight_step <= STEP_W'(WSTEP_RESET);
      cfg_q.length_step <= STEP_W'(LSTEP_RESET);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_TARE: begin
          cfg_q.tare_cg <= TARE_CG_W'(cfg_wdata_i[TARE_W-1:0]) * TARE_CG_W'(CG_PER_G);
        end
        CFG_GAIN: begin
          cfg_q.gain <= cfg_wdata_i[GAIN_W-1:0];
        end
        CFG_WSTEP: begin
          cfg_q.weight_step <= cfg_wdata_i[STEP_W-1:0];
        end
        CFG_LSTEP: begin
          cfg_q.length_step <= cfg_wdata_i[STEP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  swal_ring #(
    .AVG_DEPTH (AVG_DEPTH),
    .TOTAL_W   (TOTAL_W)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_sample_i (sample_i.sample_cg),
    .in_ready_o  (sample_i.ready),
    .tot_valid_o (tot_valid),
    .tot_o       (tot),
    .tot_ready_i (tot_ready)
  );

  swal_net #(
    .AVG_DEPTH (AVG_DEPTH),
    .TOTAL_W   (TOTAL_W)
  ) u_net (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tot_valid_i (tot_valid),
    .tot_i       (tot),
    .tot_ready_o (tot_ready),
    .tare_cg_i   (cfg_q.tare_cg),
    .net_o       (net_stage),
    .net_ready_i (net_ready)
  );

  swal_len u_len (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .net_i       (net_stage),
    .net_ready_o (net_ready),
    .cfg_i       (cfg_q),
    .result_o    (result_o)
  );

endmodule

/* verif/tb_top.sv */
// Testbench for the spool weight average to length unit: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
  import swal_pkg::*;

  localparam int AVG_DEPTH     = 5;
  localparam int SETTLE_CYCLES = 10;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 70;
  localparam int HOLD_AT       = 195;
  localparam int HOLD_CYCLES   = 80;
  localparam int SAMPLE_MAX    = 2097151;
  localparam int SAMPLE_MIN    = -2097152;

  typedef struct packed {
    logic signed [NET_W-1:0] net_cg;
    logic [LEN_W-1:0]        length_cm;
    logic                    is_empty;
    logic                    weight_changed;
    logic                    length_changed;
  } spool_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e     kind;
    cfg_reg_e      reg_idx;
    int            value;
    bit            typed;
    spool_result_t typed_res;
  } stim_row_t;

  localparam spool_result_t NO_RES = '0;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  swal_in_if  sample_if ();
  swal_out_if result_if ();

  spool_weight_average_to_length_unit #(
    .AVG_DEPTH(AVG_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .sample_i   (sample_if),
    .result_o   (result_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Rows with a typed result are the ones whose outcome is plain by inspection.
  stim_row_t directed_rows [30] = '{
    '{ROW_SAMPLE, CFG_TARE,  0,          1'b1, '{-25000, 0, 1'b1, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_TARE,  -1,         1'b1, '{-25000, 0, 1'b1, 1'b0, 1'b0}},
    '{ROW_SAMPLE, CFG_TARE,  SAMPLE_MAX, 1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  SAMPLE_MAX, 1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  SAMPLE_MAX, 1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  SAMPLE_MAX, 1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  SAMPLE_MAX, 1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  SAMPLE_MAX, 1'b0, NO_RES},
    '{ROW_WRITE,  CFG_WSTEP, 0,          1'b0, NO_RES},
    '{ROW_WRITE,  CFG_LSTEP, 0,          1'b0, NO_RES},
    '{ROW_WRITE,  CFG_TARE,  0,          1'b0, NO_RES},
    '{ROW_WRITE,  CFG_GAIN,  262143,     1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  SAMPLE_MAX, 1'b1, '{2000000, 700000, 1'b0, 1'b0, 1'b1}},
    '{ROW_SAMPLE, CFG_TARE,  2097150,    1'b0, NO_RES},
    '{ROW_WRITE,  CFG_TARE,  8191,       1'b0, NO_RES},
    '{ROW_WRITE,  CFG_WSTEP, 65535,      1'b0, NO_RES},
    '{ROW_WRITE,  CFG_LSTEP, 65535,      1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  SAMPLE_MIN, 1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  SAMPLE_MIN, 1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  SAMPLE_MIN, 1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  SAMPLE_MIN, 1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  SAMPLE_MIN, 1'b1, '{-2500000, 0, 1'b1, 1'b0, 1'b0}},
    '{ROW_WRITE,  CFG_GAIN,  0,          1'b0, NO_RES},
    '{ROW_WRITE,  CFG_TARE,  0,          1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  2000000,    1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  2000000,    1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  2000000,    1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  2000000,    1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  2000000,    1'b0, NO_RES},
    '{ROW_SAMPLE, CFG_TARE,  -2000000,   1'b0, NO_RES}
  };

  // Mirror of the block state and registers.
  logic signed [SAMPLE_W-1:0] ring_samples [AVG_DEPTH];
  int                         ring_slot;
  longint                     ring_total;
  longint                     shown_weight;
  longint                     shown_length;
  logic [TARE_W-1:0]          tare_g;
  logic [GAIN_W-1:0]          gain_q16;
  logic [STEP_W-1:0]          weight_step;
  logic [STEP_W-1:0]          length_step;

  spool_result_t pending_results [$];
  int            error_count  = 0;
  int            results_seen = 0;

  function automatic longint magnitude_of(input longint d);
    return (d < 0) ? -d : d;
  endfunction

  function automatic spool_result_t fold_sample(input logic signed [SAMPLE_W-1:0] s);
    longint        avg_cg;
    longint        net_cg;
    longint        len_cm;
    spool_result_t r;
    ring_total = ring_total + longint'(s) - longint'(ring_samples[ring_slot]);
    ring_samples[ring_slot] = s;
    ring_slot = (ring_slot == AVG_DEPTH - 1) ? 0 : ring_slot + 1;
    avg_cg = ring_total / longint'(AVG_DEPTH);
    net_cg = avg_cg - longint'(tare_g) * longint'(CG_PER_G);
    if (net_cg < longint'(NET_MIN)) net_cg = longint'(NET_MIN);
    if (net_cg > longint'(NET_MAX)) net_cg = longint'(NET_MAX);
    r = '0;
    r.net_cg = net_cg[NET_W-1:0];
    if (net_cg <= 0) begin
      r.is_empty = 1'b1;
      shown_weight = longint'(SHOWN_RESET);
      shown_length = longint'(SHOWN_RESET);
    end else begin
      len_cm = (net_cg * longint'(gain_q16)) >>> GAIN_FRAC;
      if (len_cm > longint'(LEN_MAX)) len_cm = longint'(LEN_MAX);
      r.length_cm = len_cm[LEN_W-1:0];
      if (magnitude_of(net_cg - shown_weight) > longint'(weight_step)) begin
        shown_weight = net_cg;
        r.weight_changed = 1'b1;
      end
      if (magnitude_of(len_cm - shown_length) > longint'(length_step)) begin
        shown_length = len_cm;
        r.length_changed = 1'b1;
      end
    end
    return r;
  endfunction

  // Called just after a rising edge; returns just after the edge of the transfer.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit typed,
                             input spool_result_t typed_res);
    bit            taken;
    spool_result_t r;
    sample_if.valid     <= 1'b1;
    sample_if.sample_cg <= s;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = sample_if.ready;
      @(posedge clk_i);
    end
    r = fold_sample(s);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int value);
    sample_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TARE:  tare_g      = value[TARE_W-1:0];
      CFG_GAIN:  gain_q16    = value[GAIN_W-1:0];
      CFG_WSTEP: weight_step = value[STEP_W-1:0];
      CFG_LSTEP: length_step = value[STEP_W-1:0];
      default: ;
    endcase
  endtask

  initial begin
    int                         base_cg;
    int                         noise_cg;
    int                         raw;
    int                         reg_val;
    int                         burst_left;
    int                         gap;
    int                         pick;
    logic signed [SAMPLE_W-1:0] smp;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_TARE;
    cfg_wdata_i         = '0;
    sample_if.valid     = 1'b0;
    sample_if.sample_cg = '0;
    foreach (ring_samples[i]) ring_samples[i] = '0;
    ring_slot    = 0;
    ring_total   = 0;
    shown_weight = longint'(SHOWN_RESET);
    shown_length = longint'(SHOWN_RESET);
    tare_g       = TARE_W'(TARE_RESET);
    gain_q16     = GAIN_W'(GAIN_RESET);
    weight_step  = STEP_W'(WSTEP_RESET);
    length_step  = STEP_W'(LSTEP_RESET);
    burst_left   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_sample(directed_rows[i].value[SAMPLE_W-1:0], directed_rows[i].typed,
                    directed_rows[i].typed_res);
      end
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0: reg_val = 0;
        1: reg_val = 5000;
        2: reg_val = 8191;
        3: reg_val = TARE_RESET;
        default: reg_val = $urandom_range(0, 5000);
      endcase
      write_reg(CFG_TARE, reg_val);
      case ($urandom_range(0, 4))
        0: reg_val = 0;
        1: reg_val = 262143;
        2: reg_val = GAIN_RESET;
        default: reg_val = $urandom_range(0, 262143);
      endcase
      write_reg(CFG_GAIN, reg_val);
      case ($urandom_range(0, 4))
        0: reg_val = 0;
        1: reg_val = 65535;
        2: reg_val = $urandom_range(0, 65535);
        default: reg_val = $urandom_range(0, 64);
      endcase
      write_reg(CFG_WSTEP, reg_val);
      case ($urandom_range(0, 4))
        0: reg_val = 0;
        1: reg_val = 65535;
        2: reg_val = $urandom_range(0, 65535);
        default: reg_val = $urandom_range(0, 64);
      endcase
      write_reg(CFG_LSTEP, reg_val);

      // Most samples hover around a slowly drifting level so that the average
      // settles and the change thresholds are crossed in both directions.
      base_cg = int'(tare_g) * CG_PER_G;
      if ($urandom_range(0, 3) == 0) base_cg += int'($urandom_range(0, 400)) - 200;
      else base_cg += int'($urandom_range(0, 400000));
      noise_cg = $urandom_range(0, 60);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if (gap > 0) begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
          burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
        end
        burst_left--;
        base_cg += int'($urandom_range(0, 40)) - 20;
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
          raw = base_cg + int'($urandom_range(0, 2 * noise_cg)) - noise_cg;
          if (raw > SAMPLE_MAX) raw = SAMPLE_MAX;
          if (raw < SAMPLE_MIN) raw = SAMPLE_MIN;
        end else if (pick == 6) begin
          raw = $urandom;
        end else if (pick == 7) begin
          case ($urandom_range(0, 5))
            0: raw = SAMPLE_MIN;
            1: raw = SAMPLE_MAX;
            2: raw = 0;
            3: raw = -1;
            4: raw = 2000000;
            default: raw = -2000000;
          endcase
        end else begin
          raw = int'($urandom_range(0, 4000000)) - 2000000;
        end
        smp = raw[SAMPLE_W-1:0];
        send_sample(smp, 1'b0, NO_RES);
      end
    end

    sample_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Receiver: changing stall patterns, plus one long hold that backs up the pipeline.
  initial begin
    int rx_mode;
    int mode_left;
    int hold_left;
    int beat;
    bit hold_done;
    rx_mode         = 0;
    mode_left       = 0;
    hold_left       = 0;
    beat            = 0;
    hold_done       = 1'b0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        result_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        beat++;
        case (rx_mode)
          0: result_if.ready <= 1'b1;
          1: result_if.ready <= 1'($urandom_range(0, 1));
          2: result_if.ready <= (beat % 4 != 3);
          default: result_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Outputs are stable at the falling edge, so a transfer is seen before the rising edge that completes it.
  always @(negedge clk_i) begin
    spool_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected, net_cg %0d", $time,
                 $signed(result_if.net_cg));
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_if.net_cg !== want.net_cg) begin
          $display("%0t: net_cg expected %0d, got %0d", $time, $signed(want.net_cg),
                   $signed(result_if.net_cg));
          error_count++;
        end
        if (result_if.length_cm !== want.length_cm) begin
          $display("%0t: length_cm expected %0d, got %0d", $time, want.length_cm,
                   result_if.length_cm);
          error_count++;
        end
        if (result_if.is_empty !== want.is_empty) begin
          $display("%0t: is_empty expected %b, got %b", $time, want.is_empty,
                   result_if.is_empty);
          error_count++;
        end
        if (result_if.weight_changed !== want.weight_changed) begin
          $display("%0t: weight_changed expected %b, got %b", $time, want.weight_changed,
                   result_if.weight_changed);
          error_count++;
        end
        if (result_if.length_changed !== want.length_changed) begin
          $display("%0t: length_changed expected %b, got %b", $time, want.length_changed,
                   result_if.length_changed);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
